>>> src/ilcl_pkg.sv
// Shared types and constants for the infrared link connect/listen manager.
package ilcl_pkg;

  typedef enum logic [3:0] {
    ST_START         = 4'd0,
    ST_IDLE          = 4'd1,
    ST_CONNECTING    = 4'd2,
    ST_LISTENING     = 4'd3,
    ST_STOP_LISTEN   = 4'd4,
    ST_DISCONNECTING = 4'd5,
    ST_CONNECTED     = 4'd6,
    ST_STOPPING2     = 4'd7,
    ST_STOPPING      = 4'd8,
    ST_STOPPED       = 4'd9
  } state_t;

  typedef enum logic [1:0] {
    EV_TIMER = 2'd0,
    EV_CONN  = 2'd1,
    EV_DISC  = 2'd2,
    EV_STOP  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_START_RETRY_LIMIT   = 2'd0,
    REG_FIRST_CONNECT_SLOTS = 2'd1,
    REG_CONNECT_SLOTS       = 2'd2
  } reg_index_t;

  localparam logic [3:0] RETRY_LIMIT_RESET   = 4'd3;
  localparam logic [4:0] FIRST_SLOTS_RESET   = 5'd1;
  localparam logic [4:0] CONNECT_SLOTS_RESET = 5'd6;
  localparam logic [4:0] RETRIES_MAX         = 5'd31;

  typedef struct packed {
    logic [3:0] start_retry_limit;
    logic [4:0] first_connect_slots;
    logic [4:0] connect_slots;
  } cfg_t;

  // Packed struct: last member sits in the lowest bits.
  typedef struct packed {
    logic       unexpected_event;
    logic       idle_disconnect;
    logic       request_disconnect;
    logic       start_listen;
    logic [4:0] discovery_slots;
    logic       try_connect;
    logic       start_stack;
    logic [3:0] link_state;
  } result_t;

endpackage

>>> src/ir_link_connect_listen_fsm.sv
// Top level of the infrared link connect/listen manager.
// Usage:
//   s_* channel carries one event per transaction:
//     s_tuser = action[1:0], s_tdata = {7'b0, lap_connected}.
//   m_* channel returns one result per event:
//     m_tdata = {1'b0, unexpected_event, idle_disconnect, request_disconnect,
//                start_listen, discovery_slots[4:0], try_connect, start_stack,
//                link_state[3:0]}.
//   cfg_* channel writes a register: index 0 start_retry_limit,
//     1 first_connect_slots, 2 connect_slots; index 3 is ignored.
//     cfg_ready is always high; write only while idle.
// The result is loaded into the output register when the event is taken.
//   Throughput: one event per cycle while m_tready is high, set by the single
//   state register update.
// Reset: state returns to start, retry count to zero, registers to 3/1/6,
//   output register empty.
// Stall: while m_tready is low and a result is held, s_tready drops; the
//   next event is taken in the same cycle the held result drains.
module ir_link_connect_listen_fsm import ilcl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] lap_connected
  input  logic [1:0] s_tuser,   // [1:0] action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [15:0] m_tdata,  // [3:0] link_state, [4] start_stack, [5] try_connect,
                                // [10:6] discovery_slots, [11] start_listen,
                                // [12] request_disconnect, [13] idle_disconnect,
                                // [14] unexpected_event
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  logic [3:0] state;
  logic [3:0] state_next;
  logic [4:0] retries;
  logic [4:0] retries_next;
  cfg_t       cfg;
  result_t    result;
  result_t    result_next;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {1'b0, result};

  ilcl_step u_step (
    .state         (state),
    .retries       (retries),
    .cfg           (cfg),
    .action        (s_tuser),
    .lap_connected (s_tdata[0]),
    .state_next    (state_next),
    .retries_next  (retries_next),
    .result        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_retry_limit   <= RETRY_LIMIT_RESET;
      cfg.first_connect_slots <= FIRST_SLOTS_RESET;
      cfg.connect_slots       <= CONNECT_SLOTS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_RETRY_LIMIT:   cfg.start_retry_limit   <= cfg_data[3:0];
        REG_FIRST_CONNECT_SLOTS: cfg.first_connect_slots <= cfg_data;
        REG_CONNECT_SLOTS:       cfg.connect_slots       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_START;
      retries  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state    <= state_next;
        retries  <= retries_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result <= result_next;
  end

endmodule

>>> src/ilcl_step.sv
// Next-state and command decode for one link event.
module ilcl_step import ilcl_pkg::*; (
  input  logic [3:0] state,
  input  logic [4:0] retries,
  input  cfg_t       cfg,
  input  logic [1:0] action,
  input  logic       lap_connected,
  output logic [3:0] state_next,
  output logic [4:0] retries_next,
  output result_t    result
);

  logic       stack;
  logic       conn;
  logic       listen;
  logic       disc;
  logic       idle_disc;
  logic       bad;
  logic [4:0] slots;
  logic       retry;

  always_comb begin
    state_next   = state;
    retries_next = retries;
    stack        = 1'b0;
    conn         = 1'b0;
    listen       = 1'b0;
    disc         = 1'b0;
    idle_disc    = 1'b0;
    bad          = 1'b0;
    slots        = '0;
    retry        = retries < {1'b0, cfg.start_retry_limit};
    case (state)
      ST_START: begin
        case (action)
          EV_TIMER: begin
            if (retries == '0) begin
              stack = 1'b1;
              conn  = 1'b1;
              slots = cfg.first_connect_slots;
            end else begin
              bad = 1'b1;
            end
          end
          EV_CONN: state_next = ST_CONNECTED;
          EV_DISC: begin
            if (retries != RETRIES_MAX) retries_next = retries + 5'd1;
            if (retry) begin
              conn  = 1'b1;
              slots = cfg.first_connect_slots;
            end else begin
              state_next = ST_IDLE;
            end
          end
          default: begin
            if (retries == '0) begin
              state_next = ST_STOPPED;
            end else begin
              state_next = ST_STOPPING2;
              disc       = 1'b1;
            end
          end
        endcase
      end
      ST_IDLE: begin
        case (action)
          EV_TIMER: begin
            state_next = ST_CONNECTING;
            conn       = 1'b1;
            slots      = cfg.connect_slots;
          end
          EV_STOP: state_next = ST_STOPPED;
          default: bad = 1'b1;
        endcase
      end
      ST_CONNECTING: begin
        case (action)
          EV_TIMER: bad = 1'b1;
          EV_CONN:  state_next = ST_CONNECTED;
          EV_DISC: begin
            state_next = ST_LISTENING;
            listen     = 1'b1;
          end
          default: begin
            state_next = ST_STOPPING2;
            disc       = 1'b1;
          end
        endcase
      end
      ST_LISTENING: begin
        case (action)
          EV_TIMER: begin
            state_next = ST_STOP_LISTEN;
            disc       = 1'b1;
          end
          EV_CONN: state_next = ST_CONNECTED;
          EV_DISC: listen = 1'b1;
          default: begin
            state_next = ST_STOPPING2;
            disc       = 1'b1;
          end
        endcase
      end
      ST_STOP_LISTEN: begin
        case (action)
          EV_DISC: state_next = ST_DISCONNECTING;
          EV_STOP: state_next = ST_STOPPING2;
          default: bad = 1'b1;
        endcase
      end
      ST_DISCONNECTING: begin
        case (action)
          EV_DISC: begin
            state_next = ST_CONNECTING;
            conn       = 1'b1;
            slots      = cfg.connect_slots;
          end
          EV_STOP: state_next = ST_STOPPING;
          default: bad = 1'b1;
        endcase
      end
      ST_CONNECTED: begin
        case (action)
          EV_CONN: bad = 1'b1;
          EV_DISC: state_next = ST_IDLE;
          EV_STOP: begin
            state_next = ST_STOPPING;
            disc       = 1'b1;
          end
          default: ;
        endcase
      end
      ST_STOPPING2: begin
        if (action == EV_CONN || action == EV_DISC) state_next = ST_STOPPING;
        else bad = 1'b1;
      end
      ST_STOPPING: begin
        if (action == EV_DISC) begin
          state_next = ST_STOPPED;
          idle_disc  = lap_connected;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    result.link_state         = state_next;
    result.start_stack        = stack;
    result.try_connect        = conn;
    result.discovery_slots    = conn ? slots : 5'd0;
    result.start_listen       = listen;
    result.request_disconnect = disc;
    result.idle_disconnect    = idle_disc;
    result.unexpected_event   = bad;
  end

endmodule

>>> tb/sv/ir_link_connect_listen_fsm_test.sv
// Self-checking stream testbench for the infrared link connect/listen manager.
module ir_link_connect_listen_fsm_test import ilcl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    event_t ev;
    logic   lap;
  } link_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  ir_link_connect_listen_fsm dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  cfg_t       link_cfg;
  state_t     link_now;
  logic [4:0] start_tries;
  logic [9:0] states_seen = '0;

  link_event_t link_event_q[$];
  result_t     link_result_q[$];
  link_event_t offered_event;

  int  send_gap = 0;
  int  rx_gap = 0;
  bit  send_gaps = 1'b0;
  bit  recv_stalls = 1'b0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  mismatches = 0;
  int  events_sent = 0;
  int  results_checked = 0;
  int  quiet_cycles = 0;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic result_t predict_link_result(event_t ev, logic lap);
    result_t r;
    state_t  nx;
    logic    retry;
    r = '0;
    nx = link_now;
    case (link_now)
      ST_START: begin
        case (ev)
          EV_TIMER: begin
            if (start_tries == '0) begin
              r.start_stack = 1'b1;
              r.try_connect = 1'b1;
              r.discovery_slots = link_cfg.first_connect_slots;
            end else begin
              r.unexpected_event = 1'b1;
            end
          end
          EV_CONN: nx = ST_CONNECTED;
          EV_DISC: begin
            retry = start_tries < {1'b0, link_cfg.start_retry_limit};
            if (start_tries != RETRIES_MAX) start_tries = start_tries + 5'd1;
            if (retry) begin
              r.try_connect = 1'b1;
              r.discovery_slots = link_cfg.first_connect_slots;
            end else begin
              nx = ST_IDLE;
            end
          end
          default: begin
            if (start_tries == '0) begin
              nx = ST_STOPPED;
            end else begin
              nx = ST_STOPPING2;
              r.request_disconnect = 1'b1;
            end
          end
        endcase
      end
      ST_IDLE: begin
        if (ev == EV_TIMER) begin
          nx = ST_CONNECTING;
          r.try_connect = 1'b1;
          r.discovery_slots = link_cfg.connect_slots;
        end else if (ev == EV_STOP) begin
          nx = ST_STOPPED;
        end else begin
          r.unexpected_event = 1'b1;
        end
      end
      ST_CONNECTING: begin
        case (ev)
          EV_TIMER: r.unexpected_event = 1'b1;
          EV_CONN: nx = ST_CONNECTED;
          EV_DISC: begin
            nx = ST_LISTENING;
            r.start_listen = 1'b1;
          end
          default: begin
            nx = ST_STOPPING2;
            r.request_disconnect = 1'b1;
          end
        endcase
      end
      ST_LISTENING: begin
        case (ev)
          EV_TIMER: begin
            nx = ST_STOP_LISTEN;
            r.request_disconnect = 1'b1;
          end
          EV_CONN: nx = ST_CONNECTED;
          EV_DISC: r.start_listen = 1'b1;
          default: begin
            nx = ST_STOPPING2;
            r.request_disconnect = 1'b1;
          end
        endcase
      end
      ST_STOP_LISTEN: begin
        if (ev == EV_DISC) nx = ST_DISCONNECTING;
        else if (ev == EV_STOP) nx = ST_STOPPING2;
        else r.unexpected_event = 1'b1;
      end
      ST_DISCONNECTING: begin
        if (ev == EV_DISC) begin
          nx = ST_CONNECTING;
          r.try_connect = 1'b1;
          r.discovery_slots = link_cfg.connect_slots;
        end else if (ev == EV_STOP) begin
          nx = ST_STOPPING;
        end else begin
          r.unexpected_event = 1'b1;
        end
      end
      ST_CONNECTED: begin
        case (ev)
          EV_CONN: r.unexpected_event = 1'b1;
          EV_DISC: nx = ST_IDLE;
          EV_STOP: begin
            nx = ST_STOPPING;
            r.request_disconnect = 1'b1;
          end
          default: ;
        endcase
      end
      ST_STOPPING2: begin
        if (ev == EV_CONN || ev == EV_DISC) nx = ST_STOPPING;
        else r.unexpected_event = 1'b1;
      end
      ST_STOPPING: begin
        if (ev == EV_DISC) begin
          nx = ST_STOPPED;
          r.idle_disconnect = lap;
        end else begin
          r.unexpected_event = 1'b1;
        end
      end
      default: r.unexpected_event = 1'b1;
    endcase
    link_now = nx;
    states_seen[nx] = 1'b1;
    r.link_state = nx;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result(logic [15:0] data);
    result_t got;
    result_t want;
    got = result_t'(data[14:0]);
    if (link_result_q.size() == 0) begin
      $error("result transaction with nothing pending: %h", data);
      mismatches++;
    end else begin
      want = link_result_q.pop_front();
      compare_field("link_state", want.link_state, got.link_state);
      compare_field("start_stack", want.start_stack, got.start_stack);
      compare_field("try_connect", want.try_connect, got.try_connect);
      compare_field("discovery_slots", want.discovery_slots, got.discovery_slots);
      compare_field("start_listen", want.start_listen, got.start_listen);
      compare_field("request_disconnect", want.request_disconnect, got.request_disconnect);
      compare_field("idle_disconnect", want.idle_disconnect, got.idle_disconnect);
      compare_field("unexpected_event", want.unexpected_event, got.unexpected_event);
      results_checked++;
    end
  endtask

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        link_result_q.push_back(predict_link_result(offered_event.ev, offered_event.lap));
        events_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (link_event_q.size() != 0) begin
          offered_event = link_event_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {7'b0, offered_event.lap};
          s_tuser <= offered_event.ev;
          send_gap = send_gaps ? draw_gap() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        rx_gap = HOLD_CYCLES;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (recv_stalls && $urandom_range(0, 3) == 0) rx_gap = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [4:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_RETRY_LIMIT:   link_cfg.start_retry_limit = value[3:0];
      REG_FIRST_CONNECT_SLOTS: link_cfg.first_connect_slots = value;
      REG_CONNECT_SLOTS:       link_cfg.connect_slots = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_event(event_t ev, logic lap);
    link_event_t item;
    item.ev = ev;
    item.lap = lap;
    link_event_q.push_back(item);
  endtask

  task automatic drain_link();
    while (link_event_q.size() != 0 || s_tvalid || link_result_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    int n;
    logic [4:0] slots;
    link_cfg.start_retry_limit = RETRY_LIMIT_RESET;
    link_cfg.first_connect_slots = FIRST_SLOTS_RESET;
    link_cfg.connect_slots = CONNECT_SLOTS_RESET;
    link_now = ST_START;
    start_tries = '0;
    states_seen[ST_START] = 1'b1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // start-up: walk the retry counter up to the limit with changing slot counts
    write_reg(REG_START_RETRY_LIMIT, 5'h0F);
    write_reg(REG_FIRST_CONNECT_SLOTS, 5'd0);
    write_reg(REG_CONNECT_SLOTS, 5'd16);
    @(negedge clk);
    queue_event(EV_TIMER, 1'($urandom_range(0, 1)));
    repeat (2) queue_event(EV_DISC, 1'($urandom_range(0, 1)));
    queue_event(EV_TIMER, 1'($urandom_range(0, 1)));
    drain_link();
    write_reg(REG_FIRST_CONNECT_SLOTS, 5'd31);
    @(negedge clk);
    repeat (5) queue_event(EV_DISC, 1'($urandom_range(0, 1)));
    drain_link();
    write_reg(REG_FIRST_CONNECT_SLOTS, 5'd16);
    @(negedge clk);
    repeat (5) queue_event(EV_DISC, 1'($urandom_range(0, 1)));
    drain_link();
    write_reg(REG_FIRST_CONNECT_SLOTS, 5'd1);
    @(negedge clk);
    repeat (3) queue_event(EV_DISC, 1'($urandom_range(0, 1)));
    queue_event(EV_TIMER, 1'($urandom_range(0, 1)));
    queue_event(EV_DISC, 1'($urandom_range(0, 1)));
    drain_link();

    // connect/listen cycling; stop requests are held back since they end the run
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_reg(REG_START_RETRY_LIMIT, 5'h10);
        1: write_reg(REG_START_RETRY_LIMIT, 5'h1F);
        default: write_reg(REG_START_RETRY_LIMIT, 5'($urandom_range(0, 31)));
      endcase
      case (p)
        0: slots = 5'd0;
        1: slots = 5'd1;
        2: slots = 5'd16;
        3: slots = 5'd31;
        4: slots = 5'd17;
        default: slots = 5'($urandom_range(0, 31));
      endcase
      write_reg(REG_CONNECT_SLOTS, slots);
      write_reg(REG_FIRST_CONNECT_SLOTS, 5'($urandom_range(0, 31)));
      if (p == 2) write_reg(REG_UNUSED, 5'($urandom_range(0, 31)));
      @(negedge clk);
      send_gaps = (p % 3 != 0) && (p != 4);
      recv_stalls = (p % 4 != 1);
      if (p == 4) hold_requests++;
      n = $urandom_range(110, 170);
      repeat (n) queue_event(event_t'($urandom_range(EV_TIMER, EV_DISC)),
                             1'($urandom_range(0, 1)));
      drain_link();
    end

    // shutdown path, then events in the stopped state
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    queue_event(EV_STOP, 1'($urandom_range(0, 1)));
    drain_link();
    if (link_now == ST_STOPPING2) begin
      queue_event($urandom_range(0, 1) ? EV_CONN : EV_DISC, 1'($urandom_range(0, 1)));
      drain_link();
    end
    if (link_now == ST_STOPPING) begin
      queue_event(EV_TIMER, 1'($urandom_range(0, 1)));
      queue_event(EV_STOP, 1'($urandom_range(0, 1)));
      queue_event(EV_DISC, 1'b1);
    end
    repeat (6) queue_event(event_t'($urandom_range(EV_TIMER, EV_STOP)),
                           1'($urandom_range(0, 1)));
    drain_link();
    repeat (5) @(negedge clk);

    $display("Run covered %0d events and %0d checked results over %0d of 10 link states,",
             events_sent, results_checked, $countones(states_seen));
    $display("with retry-limit and slot registers swept across their extremes.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/ilcl_pkg.sv
src/ilcl_step.sv
src/ir_link_connect_listen_fsm.sv
tb/sv/ir_link_connect_listen_fsm_test.sv
